// File: hw/rtl/ezr_pkg.sv
`timescale 1ns / 1ps
package ezr_pkg;

    // Fixed-point trig constants, signed Q4.30 (34 bits, 30 fraction bits).
    localparam int TRIG_W = 34;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [TRIG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam int ATAN_DEPTH = 30;

    // Arctangent table for the CORDIC steps.
    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [TRIG_W-1:0] r;
        begin
            case (idx)
                5'd0:  r = 34'sh03243F6A8;
                5'd1:  r = 34'sh01DAC6705;
                5'd2:  r = 34'sh00FADBAFC;
                5'd3:  r = 34'sh007F56EA6;
                5'd4:  r = 34'sh003FEAB76;
                5'd5:  r = 34'sh001FFD55B;
                5'd6:  r = 34'sh000FFFAAA;
                5'd7:  r = 34'sh0007FFF55;
                5'd8:  r = 34'sh0003FFFEA;
                5'd9:  r = 34'sh0001FFFFD;
                5'd10: r = 34'sh0000FFFFF;
                5'd11: r = 34'sh00007FFFF;
                5'd12: r = 34'sh00003FFFF;
                5'd13: r = 34'sh00001FFFF;
                5'd14: r = 34'sh00000FFFF;
                5'd15: r = 34'sh000007FFF;
                5'd16: r = 34'sh000003FFF;
                5'd17: r = 34'sh000001FFF;
                5'd18: r = 34'sh000000FFF;
                5'd19: r = 34'sh0000007FF;
                5'd20: r = 34'sh0000003FF;
                5'd21: r = 34'sh0000001FF;
                5'd22: r = 34'sh0000000FF;
                5'd23: r = 34'sh00000007F;
                5'd24: r = 34'sh00000003F;
                5'd25: r = 34'sh00000001F;
                5'd26: r = 34'sh00000000F;
                5'd27: r = 34'sh000000008;
                5'd28: r = 34'sh000000004;
                5'd29: r = 34'sh000000002;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Q30 product with round half up: (a*b + 2^29) >>> 30.
    function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            return TRIG_W'(p >>> 30);
        end
    endfunction

endpackage

// File: hw/rtl/euler_zyx_vector_rotation.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake       | Payload
// input   | sink      | in_valid/ready  | mode, vec_x/y/z, angle_first/second/third
// output  | source    | out_valid/ready | rot_x/y/z, clipped
//
// One word enters per cycle while the output is not stalled. The pipeline has one fold
// stage, one CORDIC stage per iteration, two matrix product stages, a coefficient stage,
// a vector product stage, and the sum and saturation stage.
// rst_n clears only the stage valid bits; the data registers are not reset.
// A stall at the output freezes the whole pipeline; in_ready is high when out_ready
// is high or the output register is empty.
module euler_zyx_vector_rotation #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_WIDTH     = 18,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    input  logic signed [ANGLE_WIDTH-1:0] angle_first,
    input  logic signed [ANGLE_WIDTH-1:0] angle_second,
    input  logic signed [ANGLE_WIDTH-1:0] angle_third,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] rot_x,
    output logic signed [COORD_WIDTH-1:0] rot_y,
    output logic signed [COORD_WIDTH-1:0] rot_z,
    output logic                          clipped
);
    import ezr_pkg::*;

    localparam int NIT   = (TRIG_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH : TRIG_ITERATIONS;
    localparam int CF    = ((60 - COORD_WIDTH) < 30) ? (60 - COORD_WIDTH) : 30;
    localparam int RB    = (CF < 30) ? (29 - CF) : 0;
    localparam int ASH   = 33 - ANGLE_WIDTH;
    localparam int PW    = TRIG_W + COORD_WIDTH;
    localparam int SW    = PW + 2;
    localparam int NST   = NIT + 6;
    localparam int CW    = COORD_WIDTH;
    localparam int IX_W  = 5;

    typedef logic signed [TRIG_W-1:0] q_t;
    typedef logic signed [CW-1:0]     crd_t;
    typedef logic signed [PW-1:0]     prd_t;
    typedef logic signed [SW-1:0]     acc_t;

    // Valid bits of every stage; all stages advance together unless blocked.
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign out_valid = vld_reg[NST-1];
    assign adv       = out_ready || !out_valid;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // Stage 0: angle scaling and range fold for each of the three angles.
    q_t   cx_reg [0:NIT][0:2];
    q_t   cy_reg [0:NIT][0:2];
    q_t   cz_reg [0:NIT][0:2];
    logic neg_reg [0:NIT][0:2];
    logic md_reg  [0:NIT+2];
    crd_t v_reg   [0:NIT+3][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q_t th;
                case (k)
                    0:       th = q_t'(angle_first)  <<< ASH;
                    1:       th = q_t'(angle_second) <<< ASH;
                    default: th = q_t'(angle_third)  <<< ASH;
                endcase
                cx_reg[0][k] <= GAIN_Q30;
                cy_reg[0][k] <= '0;
                if (th > HALF_PI_Q30)
                begin
                    cz_reg[0][k]  <= th - PI_Q30;
                    neg_reg[0][k] <= 1'b1;
                end
                else if (th < -HALF_PI_Q30)
                begin
                    cz_reg[0][k]  <= th + PI_Q30;
                    neg_reg[0][k] <= 1'b1;
                end
                else
                begin
                    cz_reg[0][k]  <= th;
                    neg_reg[0][k] <= 1'b0;
                end
            end
            md_reg[0]   <= mode;
            v_reg[0][0] <= vec_x;
            v_reg[0][1] <= vec_y;
            v_reg[0][2] <= vec_z;
        end
    end

    // CORDIC stages, one micro-rotation each.
    for (genvar i = 0; i < NIT; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (cz_reg[i][k] >= 0)
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] - (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] + (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] - atan_q30(IX_W'(i));
                    end
                    else
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] + (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] - (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] + atan_q30(IX_W'(i));
                    end
                    neg_reg[i+1][k] <= neg_reg[i][k];
                end
                md_reg[i+1] <= md_reg[i];
                v_reg[i+1]  <= v_reg[i];
            end
        end
    end

    // Sign-corrected cosines and sines.
    q_t c0, s0, c1, s1, c2, s2;
    assign c0 = neg_reg[NIT][0] ? -cx_reg[NIT][0] : cx_reg[NIT][0];
    assign s0 = neg_reg[NIT][0] ? -cy_reg[NIT][0] : cy_reg[NIT][0];
    assign c1 = neg_reg[NIT][1] ? -cx_reg[NIT][1] : cx_reg[NIT][1];
    assign s1 = neg_reg[NIT][1] ? -cy_reg[NIT][1] : cy_reg[NIT][1];
    assign c2 = neg_reg[NIT][2] ? -cx_reg[NIT][2] : cx_reg[NIT][2];
    assign s2 = neg_reg[NIT][2] ? -cy_reg[NIT][2] : cy_reg[NIT][2];

    // Matrix stage A: the pairwise products that R needs, plus -s1, c2 and s2 passed on.
    q_t c0s1_reg, s0s1_reg, s0c2_reg, s0s2_reg, c0c2_reg, c0s2_reg;
    q_t r00a_reg, r10a_reg, r20a_reg, r21a_reg, r22a_reg, c2a_reg, s2a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0s1_reg <= mulq(c0, s1);
            s0s1_reg <= mulq(s0, s1);
            s0c2_reg <= mulq(s0, c2);
            s0s2_reg <= mulq(s0, s2);
            c0c2_reg <= mulq(c0, c2);
            c0s2_reg <= mulq(c0, s2);
            r00a_reg <= mulq(c0, c1);
            r10a_reg <= mulq(s0, c1);
            r20a_reg <= -s1;
            r21a_reg <= mulq(c1, s2);
            r22a_reg <= mulq(c1, c2);
            c2a_reg  <= c2;
            s2a_reg  <= s2;
            md_reg[NIT+1] <= md_reg[NIT];
            v_reg[NIT+1]  <= v_reg[NIT];
        end
    end

    // Matrix stage B: triple products and final entries in Q30.
    q_t rq_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rq_reg[0][0] <= r00a_reg;
            rq_reg[0][1] <= mulq(c0s1_reg, s2a_reg) - s0c2_reg;
            rq_reg[0][2] <= mulq(c0s1_reg, c2a_reg) + s0s2_reg;
            rq_reg[1][0] <= r10a_reg;
            rq_reg[1][1] <= mulq(s0s1_reg, s2a_reg) + c0c2_reg;
            rq_reg[1][2] <= mulq(s0s1_reg, c2a_reg) - c0s2_reg;
            rq_reg[2][0] <= r20a_reg;
            rq_reg[2][1] <= r21a_reg;
            rq_reg[2][2] <= r22a_reg;
            md_reg[NIT+2] <= md_reg[NIT+1];
            v_reg[NIT+2]  <= v_reg[NIT+1];
        end
    end

    // Coefficient stage: round to CF fraction bits and pick R or its transpose.
    q_t rc_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    q_t e;
                    e = md_reg[NIT+2] ? rq_reg[b][a] : rq_reg[a][b];
                    if (CF < 30)
                        rc_reg[a][b] <= (e + (q_t'(1) <<< RB)) >>> (RB + 1);
                    else
                        rc_reg[a][b] <= e;
                end
            end
            v_reg[NIT+3]  <= v_reg[NIT+2];
        end
    end

    // Product stage: nine coefficient by coordinate products.
    prd_t pr_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    pr_reg[a][b] <= prd_t'(rc_reg[a][b]) * prd_t'(v_reg[NIT+3][b]);
                end
            end
        end
    end

    // Output stage: sum, round, saturate.
    crd_t rot_reg [0:2];
    logic clip_reg;
    localparam acc_t MAXV = acc_t'((64'sd1 <<< (CW - 1)) - 1);
    localparam acc_t MINV = -MAXV - acc_t'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic cl;
            cl = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                acc_t s;
                s = acc_t'(pr_reg[a][0]) + acc_t'(pr_reg[a][1]) + acc_t'(pr_reg[a][2]);
                s = (s + (acc_t'(1) <<< (CF - 1))) >>> CF;
                if (s > MAXV)
                begin
                    s  = MAXV;
                    cl = 1'b1;
                end
                else if (s < MINV)
                begin
                    s  = MINV;
                    cl = 1'b1;
                end
                rot_reg[a] <= crd_t'(s);
            end
            clip_reg <= cl;
        end
    end

    assign rot_x   = rot_reg[0];
    assign rot_y   = rot_reg[1];
    assign rot_z   = rot_reg[2];
    assign clipped = clip_reg;

    // A stalled output holds the pipeline still.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vld_reg))
        else $error("pipeline moved during stall");

    // A word accepted at the input shows up in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted word lost");

    // Ready is high whenever the output slot is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("ready low with empty output");

endmodule
